>>> rtl/rtc3w_pkg.sv
package rtc3w_pkg;

    // Command kinds; the start codes of the action field share these values
    typedef enum logic [1:0] {
        KIND_IDLE = 2'd0,
        KIND_SET  = 2'd1,
        KIND_READ = 2'd2,
        KIND_NONE = 2'd3
    } t_kind;

    // Tick phases within one frame
    typedef enum logic [1:0] {
        PH_SETUP = 2'd0,
        PH_LOW   = 2'd1,
        PH_HIGH  = 2'd2,
        PH_END   = 2'd3
    } t_phase;

    localparam logic [7:0] WP_ADDR  = 8'h8E;
    localparam logic [7:0] WP_SET   = 8'h80;
    localparam logic [7:0] WP_CLEAR = 8'h00;
    localparam logic [7:0] READ_BIT = 8'h01;

    // Sequencer state carried from tick to tick
    typedef struct packed {
        t_kind       kind;
        logic [1:0]  frame_index;
        logic [4:0]  bit_counter;
        t_phase      phase;
        logic [15:0] frame_shift;
        logic [7:0]  receive_shift;
        logic [7:0]  held_address;
        logic [7:0]  held_bcd;
        logic        pin_ce;
        logic        pin_clk;
        logic        pin_io;
    } t_state;

    // One result transaction
    typedef struct packed {
        logic       ce_pin;
        logic       sclk_pin;
        logic       io_out;
        logic       io_drive;
        logic       busy_res;
        logic       done_res;
        logic       ignored;
        logic [7:0] read_raw;
        logic [6:0] read_value;
    } t_result;

endpackage

>>> rtl/rtc3w_step.sv
module rtc3w_step (
    input  rtc3w_pkg::t_state  i_state,
    input  logic [1:0]         i_action,
    input  logic [7:0]         i_reg_address,
    input  logic [6:0]         i_value,
    input  logic               i_io_in,
    output rtc3w_pkg::t_state  o_state,
    output rtc3w_pkg::t_result o_result
);
    import rtc3w_pkg::*;

    logic [14:0] bcd_prod;
    logic [3:0]  bcd_tens;
    logic [6:0]  bcd_ones;
    logic [7:0]  bcd_byte;
    logic [6:0]  dec_tens;

    // Pick the 16-bit frame for the current command and frame index
    function automatic logic [15:0] frame_word(t_kind kind, logic [1:0] fidx,
                                               logic [7:0] addr, logic [7:0] bcd);
        logic [15:0] w;
        if (kind == KIND_READ) begin
            w = {8'h00, addr | READ_BIT};
        end else if (fidx == 2'd0) begin
            w = {WP_CLEAR, WP_ADDR};
        end else if (fidx == 2'd1) begin
            w = {bcd, addr};
        end else begin
            w = {WP_SET, WP_ADDR};
        end
        return w;
    endfunction

    // Binary to BCD: divide by ten through a reciprocal multiply
    always_comb begin
        bcd_prod = 15'(i_value) * 15'd205;
        bcd_tens = bcd_prod[14:11];
        bcd_ones = i_value - ({bcd_tens, 3'b000} + {2'b00, bcd_tens, 1'b0});
        bcd_byte = {bcd_tens, bcd_ones[3:0]};
    end

    // Advance the sequencer by one tick
    always_comb begin
        t_state s;
        logic   start;
        logic   rx;
        logic   drive;
        logic   busy;
        logic   done;
        logic   ign;

        s     = i_state;
        start = (i_action == KIND_SET) || (i_action == KIND_READ);
        drive = 1'b1;
        busy  = 1'b0;
        done  = 1'b0;
        ign   = 1'b0;

        if (s.kind == KIND_IDLE) begin
            if (start) begin
                s.kind         = t_kind'(i_action);
                s.frame_index  = 2'd0;
                s.held_address = i_reg_address;
                s.held_bcd     = bcd_byte;
                s.frame_shift  = frame_word(s.kind, 2'd0, i_reg_address, bcd_byte);
                s.phase        = PH_SETUP;
                s.bit_counter  = 5'd0;
            end
        end else if (start) begin
            ign = 1'b1;
        end

        rx = (s.kind == KIND_READ) && (s.bit_counter[4] || s.bit_counter[3]);

        if (s.kind != KIND_IDLE) begin
            busy = 1'b1;
            case (s.phase)
                PH_SETUP: begin
                    s.pin_ce      = 1'b1;
                    s.pin_clk     = 1'b0;
                    s.phase       = PH_LOW;
                    s.bit_counter = 5'd0;
                end
                PH_LOW: begin
                    if (rx) begin
                        drive           = 1'b0;
                        s.receive_shift = {i_io_in, s.receive_shift[7:1]};
                    end else begin
                        s.pin_io = s.frame_shift[s.bit_counter[3:0]];
                    end
                    s.pin_ce  = 1'b1;
                    s.pin_clk = 1'b0;
                    s.phase   = PH_HIGH;
                end
                PH_HIGH: begin
                    if (rx) begin
                        drive = 1'b0;
                    end
                    s.pin_ce      = 1'b1;
                    s.pin_clk     = 1'b1;
                    s.bit_counter = s.bit_counter + 5'd1;
                    s.phase       = s.bit_counter[4] ? PH_END : PH_LOW;
                end
                default: begin
                    if (s.kind == KIND_READ) begin
                        drive = 1'b0;
                    end
                    s.pin_ce  = 1'b0;
                    s.pin_clk = 1'b1;
                    if (s.kind == KIND_SET && s.frame_index != 2'd2
                            && s.frame_index != 2'd3) begin
                        s.frame_index = s.frame_index + 2'd1;
                        s.frame_shift = frame_word(s.kind, s.frame_index,
                                                   s.held_address, s.held_bcd);
                        s.phase       = PH_SETUP;
                        s.bit_counter = 5'd0;
                    end else begin
                        done          = 1'b1;
                        s.kind        = KIND_IDLE;
                        s.frame_index = 2'd0;
                        s.bit_counter = 5'd0;
                        s.phase       = PH_SETUP;
                    end
                end
            endcase
        end

        // Tens digit of the received byte, times ten
        dec_tens = {1'b0, s.receive_shift[6:4], 3'b000}
                 + {3'b000, s.receive_shift[6:4], 1'b0};

        o_state             = s;
        o_result.ce_pin     = s.pin_ce;
        o_result.sclk_pin   = s.pin_clk;
        o_result.io_out     = s.pin_io;
        o_result.io_drive   = drive;
        o_result.busy_res   = busy;
        o_result.done_res   = done;
        o_result.ignored    = ign;
        o_result.read_raw   = s.receive_shift;
        o_result.read_value = dec_tens + {3'b000, s.receive_shift[3:0]};
    end

endmodule

>>> rtl/rtc_three_wire_master_core.sv
// Three-wire RTC serial master, one pin tick per input transaction.
// Each result is registered into the output register, or into the skid register under output stall.
// Throughput: one transaction per cycle while o_stall is low; the next-state step is one short
// combinational pass, and a skid register takes one more transaction under output stall.
// Reset (synchronous, active low) returns the sequencer to idle, pins low,
// all shift and hold registers zero, and empties the output stages.
module rtc_three_wire_master_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_action,
    input  logic [7:0] i_reg_address,
    input  logic [6:0] i_value,
    input  logic       i_io_in,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_ce_pin,
    output logic       o_sclk_pin,
    output logic       o_io_out,
    output logic       o_io_drive,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic       o_ignored,
    output logic [7:0] o_read_raw,
    output logic [6:0] o_read_value
);
    import rtc3w_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    t_result r_out;
    t_result r_skid;
    logic    r_out_valid;
    logic    r_skid_valid;
    logic    in_accept;
    logic    out_take;

    rtc3w_step u_step (
        .i_state       (r_state),
        .i_action      (i_action),
        .i_reg_address (i_reg_address),
        .i_value       (i_value),
        .i_io_in       (i_io_in),
        .o_state       (n_state),
        .o_result      (n_result)
    );

    assign o_stall   = r_skid_valid;
    assign o_valid   = r_out_valid;
    assign in_accept = i_valid && !r_skid_valid;
    assign out_take  = r_out_valid && !i_stall;

    // Advance sequencer state on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    // Output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (in_accept) begin
            if (!r_out_valid || out_take) begin
                r_out       <= n_result;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= n_result;
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_ce_pin     = r_out.ce_pin;
    assign o_sclk_pin   = r_out.sclk_pin;
    assign o_io_out     = r_out.io_out;
    assign o_io_drive   = r_out.io_drive;
    assign o_busy_res   = r_out.busy_res;
    assign o_done_res   = r_out.done_res;
    assign o_ignored    = r_out.ignored;
    assign o_read_raw   = r_out.read_raw;
    assign o_read_value = r_out.read_value;

endmodule
